>>> sv/rcnt_pkg.sv
package rcnt_pkg;

    // Action codes carried by each input word
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // Register byte offsets within one counter
    localparam logic [3:0] OFF_COUNT  = 4'd0;
    localparam logic [3:0] OFF_MODE   = 4'd4;
    localparam logic [3:0] OFF_TARGET = 4'd8;

    // Number of counters
    localparam int unsigned NUM_CHAN = 3;

    // Mode word bit positions
    localparam int unsigned MB_SYNC      = 0;
    localparam int unsigned MB_RESET_TGT = 3;
    localparam int unsigned MB_IRQ_TGT   = 4;
    localparam int unsigned MB_IRQ_FFFF  = 5;
    localparam int unsigned MB_REPEAT    = 6;
    localparam int unsigned MB_TOGGLE    = 7;
    localparam int unsigned MB_SRC_LO    = 8;
    localparam int unsigned MB_SRC_HI    = 9;
    localparam int unsigned MB_IRQ_FLAG  = 10;

    // Gate sync modes
    localparam logic [1:0] SYNC_PAUSE_HIGH = 2'd0;
    localparam logic [1:0] SYNC_ZERO_FALL  = 2'd1;
    localparam logic [1:0] SYNC_ZERO_RISE  = 2'd2;
    localparam logic [1:0] SYNC_FREE_FALL  = 2'd3;

    // Input word
    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  timer_select;
        logic [3:0]  register_offset;
        logic [15:0] write_data;
        logic        dot_tick;
        logic        hblank_tick;
        logic        gate_level_zero;
        logic        gate_level_one;
        logic [2:0]  irq_pending;
    } rcnt_in_t;

    // Result word
    typedef struct packed {
        logic [15:0] read_data;
        logic [2:0]  irq_raise;
    } rcnt_out_t;

    // Per-counter control for one processed word
    typedef struct packed {
        logic        step;
        logic        tick;
        logic        rd;
        logic        wr;
        logic [3:0]  offset;
        logic [15:0] wdata;
        logic        alt_tick;
        logic        gate_level;
        logic        gated;
        logic        pending;
    } rcnt_ctrl_t;

endpackage

>>> sv/rcnt_prescaler.sv
module rcnt_prescaler
    import rcnt_pkg::*;
#(
    parameter int unsigned PRESCALE_DIV = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic tick,
    output logic strobe
);

    localparam int unsigned PHASE_W = (PRESCALE_DIV > 2) ? $clog2(PRESCALE_DIV) : 1;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PRESCALE_DIV - 1);

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;

    // The phase advances on every system tick and wraps at the divider
    always_comb
    begin
        phase_next = phase_reg;
        strobe     = 1'b0;
        if (tick)
        begin
            if (phase_reg == PHASE_LAST)
            begin
                phase_next = '0;
                strobe     = 1'b1;
            end
            else
            begin
                phase_next = phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

>>> sv/rcnt_channel.sv
module rcnt_channel
    import rcnt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rcnt_ctrl_t  ctrl,
    output logic [15:0] rdata,
    output logic        raise
);

    logic [15:0] count_reg,  count_next;
    logic [15:0] target_reg, target_next;
    logic [15:0] mode_reg,   mode_next;
    logic        sync_reg,   sync_next;
    logic        tflag_reg,  tflag_next;
    logic        oflag_reg,  oflag_next;
    logic        gate_reg,   gate_next;

    logic [1:0]  gate_mode;
    logic        count_en;
    logic        clk_en;
    logic        tgt_mode;
    logic [16:0] inc;
    logic        at_end;
    logic        fire;
    logic        status_irq;

    assign gate_mode = mode_reg[2:1];

    always_comb
    begin
        count_next  = count_reg;
        target_next = target_reg;
        mode_next   = mode_reg;
        sync_next   = sync_reg;
        tflag_next  = tflag_reg;
        oflag_next  = oflag_reg;
        gate_next   = gate_reg;
        rdata       = '0;
        raise       = 1'b0;
        count_en    = 1'b0;
        clk_en      = 1'b0;
        tgt_mode    = 1'b0;
        inc         = '0;
        at_end      = 1'b0;
        fire        = 1'b0;
        status_irq  = 1'b0;

        if (ctrl.step && ctrl.tick)
        begin
            // Gate edges are taken before counting
            if (ctrl.gated && (ctrl.gate_level != gate_reg))
            begin
                gate_next = ctrl.gate_level;
                if (sync_reg)
                begin
                    case (gate_mode)
                        SYNC_ZERO_FALL:
                        begin
                            if (!ctrl.gate_level)
                                count_next = '0;
                        end
                        SYNC_ZERO_RISE:
                        begin
                            if (ctrl.gate_level)
                                count_next = '0;
                        end
                        SYNC_FREE_FALL:
                        begin
                            if (!ctrl.gate_level)
                                sync_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Counting enable from the sync mode and the current gate level
            if (!sync_next)
            begin
                count_en = 1'b1;
            end
            else if (!ctrl.gated)
            begin
                count_en = (gate_mode == SYNC_ZERO_FALL) || (gate_mode == SYNC_ZERO_RISE);
            end
            else
            begin
                case (gate_mode)
                    SYNC_PAUSE_HIGH: count_en = !gate_next;
                    SYNC_ZERO_FALL:  count_en = 1'b1;
                    default:         count_en = gate_next;
                endcase
            end

            // Gated counters use source bit 8, the prescaled one bit 9
            if (ctrl.gated)
                clk_en = mode_reg[MB_SRC_LO] ? ctrl.alt_tick : 1'b1;
            else
                clk_en = mode_reg[MB_SRC_HI] ? ctrl.alt_tick : 1'b1;

            // Increment, ending the period at the target or on wrap
            tgt_mode = mode_reg[MB_RESET_TGT] && (target_reg != '0);
            inc      = {1'b0, count_next} + 17'd1;
            at_end   = tgt_mode ? (inc >= {1'b0, target_reg}) : inc[16];

            if (count_en && clk_en)
            begin
                if (!at_end)
                begin
                    count_next = inc[15:0];
                end
                else
                begin
                    count_next = '0;
                    if (tgt_mode)
                    begin
                        tflag_next = 1'b1;
                        fire       = mode_reg[MB_IRQ_TGT];
                    end
                    else
                    begin
                        oflag_next = 1'b1;
                        fire       = mode_reg[MB_IRQ_FFFF];
                    end
                end
            end

            // Interrupt in pulse or toggle form; one-shot clears its enables
            if (fire)
            begin
                if (mode_reg[MB_TOGGLE] && mode_reg[MB_IRQ_FLAG])
                begin
                    mode_next[MB_IRQ_FLAG] = 1'b0;
                end
                else
                begin
                    mode_next[MB_IRQ_FLAG] = 1'b1;
                    raise                  = !ctrl.pending;
                end
                if (!mode_reg[MB_REPEAT])
                begin
                    mode_next[MB_IRQ_TGT]  = 1'b0;
                    mode_next[MB_IRQ_FFFF] = 1'b0;
                end
            end
        end
        else if (ctrl.step && ctrl.rd)
        begin
            // Register reads; a mode read returns status and clears the flags
            case (ctrl.offset)
                OFF_COUNT:
                begin
                    rdata = count_reg;
                end
                OFF_MODE:
                begin
                    status_irq = (tflag_reg && mode_reg[MB_IRQ_TGT])
                              || (oflag_reg && mode_reg[MB_IRQ_FFFF]);
                    rdata      = {mode_reg[15:13], oflag_reg, tflag_reg, status_irq,
                                  mode_reg[9:0]};
                    tflag_next = 1'b0;
                    oflag_next = 1'b0;
                end
                OFF_TARGET:
                begin
                    rdata = target_reg;
                end
                default:
                begin
                end
            endcase
        end
        else if (ctrl.step && ctrl.wr)
        begin
            // Register writes; a mode write restarts the counter
            case (ctrl.offset)
                OFF_COUNT:
                begin
                    count_next = ctrl.wdata;
                end
                OFF_MODE:
                begin
                    mode_next              = ctrl.wdata;
                    mode_next[MB_IRQ_FLAG] = 1'b0;
                    count_next             = '0;
                    tflag_next             = 1'b0;
                    oflag_next             = 1'b0;
                    sync_next              = ctrl.wdata[MB_SYNC];
                    if (ctrl.wdata[MB_IRQ_TGT] && (target_reg == '0))
                    begin
                        mode_next[MB_IRQ_FLAG] = 1'b1;
                        raise                  = 1'b1;
                    end
                end
                OFF_TARGET:
                begin
                    target_next = ctrl.wdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            target_reg <= '0;
            mode_reg   <= '0;
            sync_reg   <= 1'b0;
            tflag_reg  <= 1'b0;
            oflag_reg  <= 1'b0;
            gate_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            target_reg <= target_next;
            mode_reg   <= mode_next;
            sync_reg   <= sync_next;
            tflag_reg  <= tflag_next;
            oflag_reg  <= oflag_next;
            gate_reg   <= gate_next;
        end
    end

endmodule

>>> sv/three_channel_gated_root_counter_core.sv
// Three 16-bit root counters with gate sync, target reset and interrupt generation. Every
// input word is a system tick, a register read or a register write and yields exactly one
// result word carrying the read data and the interrupt raise mask. A word is captured in an
// input register, processed against the counter state and placed in a result register, so
// one word is taken every clock cycle while the result side does not stall, and its result
// is offered from the result register; a stall on the result side holds at most one word in
// each register. Counter two's slow source ticks once every PRESCALE_DIV system ticks.
module three_channel_gated_root_counter_core
    import rcnt_pkg::*;
#(
    parameter int unsigned PRESCALE_DIV = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  rcnt_in_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output rcnt_out_t result
);

    logic       in_valid_reg;
    rcnt_in_t   in_word_reg;
    logic       res_valid_reg;
    rcnt_out_t  res_word_reg;

    logic       advance;
    logic       is_tick;
    logic       pre_strobe;
    rcnt_ctrl_t ctrl [NUM_CHAN];
    logic [15:0] chan_rdata [NUM_CHAN];
    logic [NUM_CHAN-1:0] chan_raise;
    logic [NUM_CHAN-1:0] alt_tick;
    logic [NUM_CHAN-1:0] gate_level;
    rcnt_out_t  res_word_next;

    // Handshake: the held word moves on when the result register is free
    assign advance      = in_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || advance;
    assign result_valid = res_valid_reg;
    assign result       = res_word_reg;
    assign is_tick      = (in_word_reg.action == ACT_TICK);

    rcnt_prescaler #(
        .PRESCALE_DIV (PRESCALE_DIV)
    ) u_prescaler (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (advance && is_tick),
        .strobe (pre_strobe)
    );

    // Per-counter alternate sources and gate lines
    assign alt_tick   = {pre_strobe, in_word_reg.hblank_tick, in_word_reg.dot_tick};
    assign gate_level = {1'b0, in_word_reg.gate_level_one, in_word_reg.gate_level_zero};

    for (genvar g = 0; g < NUM_CHAN; g++)
    begin : g_chan
        always_comb
        begin
            ctrl[g].step       = advance;
            ctrl[g].tick       = is_tick;
            ctrl[g].rd         = (in_word_reg.action == ACT_READ)
                              && (in_word_reg.timer_select == 2'(g));
            ctrl[g].wr         = (in_word_reg.action == ACT_WRITE)
                              && (in_word_reg.timer_select == 2'(g));
            ctrl[g].offset     = in_word_reg.register_offset;
            ctrl[g].wdata      = in_word_reg.write_data;
            ctrl[g].alt_tick   = alt_tick[g];
            ctrl[g].gate_level = gate_level[g];
            ctrl[g].gated      = (g < NUM_CHAN - 1);
            ctrl[g].pending    = in_word_reg.irq_pending[g];
        end

        rcnt_channel u_channel (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl[g]),
            .rdata (chan_rdata[g]),
            .raise (chan_raise[g])
        );
    end

    // Only the addressed counter drives read data, so the words are ORed
    always_comb
    begin
        res_word_next.read_data = chan_rdata[0] | chan_rdata[1] | chan_rdata[2];
        res_word_next.irq_raise = chan_raise;
    end

    // Input and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                res_valid_reg <= 1'b1;
            else if (result_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            in_word_reg <= item;
        if (advance)
            res_word_reg <= res_word_next;
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
    import rcnt_pkg::*;

    // Stimulus constants that the package does not name
    localparam int unsigned PRESCALE     = 8;
    localparam logic [1:0]  ACT_NONE     = 2'd3;
    localparam logic [1:0]  SEL_NONE     = 2'd3;
    localparam logic [3:0]  OFF_UNMAPPED = 4'd15;
    localparam int unsigned MB_TGT_HIT   = 11;
    localparam int unsigned MB_OVF_HIT   = 12;
    localparam int unsigned IN_W         = $bits(rcnt_in_t);

    localparam logic [15:0] MODE_SYNC      = 16'd1 << MB_SYNC;
    localparam logic [15:0] MODE_RESET_TGT = 16'd1 << MB_RESET_TGT;
    localparam logic [15:0] MODE_IRQ_TGT   = 16'd1 << MB_IRQ_TGT;
    localparam logic [15:0] MODE_IRQ_FFFF  = 16'd1 << MB_IRQ_FFFF;
    localparam logic [15:0] MODE_REPEAT    = 16'd1 << MB_REPEAT;
    localparam logic [15:0] MODE_TOGGLE    = 16'd1 << MB_TOGGLE;
    localparam logic [15:0] STATUS_MASK    = 16'h1C00;
    localparam logic [16:0] FULL_PERIOD    = 17'h10000;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    rcnt_in_t  item         = '0;
    logic      result_ready = 1'b0;
    logic      item_ready;
    logic      result_valid;
    rcnt_out_t result;

    // Pacing of both sides
    logic        no_idle    = 1'b0;
    int unsigned idle_pct   = 0;
    int unsigned stall_pct  = 0;
    int unsigned stall_left = 0;

    // Bookkeeping
    rcnt_out_t   expected_q[$];
    int unsigned words_sent = 0;
    int unsigned mismatches = 0;
    logic        gate_drive[2];

    // Shadow copy of the counter state
    logic [15:0] count_m[NUM_CHAN];
    logic [15:0] target_m[NUM_CHAN];
    logic [15:0] mode_m[NUM_CHAN];
    logic        sync_m[NUM_CHAN];
    logic        tgt_hit_m[NUM_CHAN];
    logic        ovf_hit_m[NUM_CHAN];
    logic        gate_m[2];
    int unsigned phase_m;

    three_channel_gated_root_counter_core #(
        .PRESCALE_DIV (PRESCALE)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Interrupt request at the end of a period, in pulse or toggle form.
    function automatic logic raise_irq(int i, logic pend);
        logic fired;
        fired = 1'b0;
        if (mode_m[i][MB_TOGGLE] && mode_m[i][MB_IRQ_FLAG])
        begin
            mode_m[i][MB_IRQ_FLAG] = 1'b0;
        end
        else
        begin
            mode_m[i][MB_IRQ_FLAG] = 1'b1;
            fired = !pend;
        end
        if (!mode_m[i][MB_REPEAT])
        begin
            mode_m[i][MB_IRQ_TGT]  = 1'b0;
            mode_m[i][MB_IRQ_FFFF] = 1'b0;
        end
        return fired;
    endfunction

    // One increment; a count at or past the period end returns to zero.
    function automatic logic step_count(int i, logic pend);
        logic        by_target;
        logic [16:0] period;
        logic [16:0] next_count;
        by_target  = mode_m[i][MB_RESET_TGT] && (target_m[i] != 16'd0);
        period     = by_target ? {1'b0, target_m[i]} : FULL_PERIOD;
        next_count = {1'b0, count_m[i]} + 17'd1;
        if (next_count < period)
        begin
            count_m[i] = next_count[15:0];
            return 1'b0;
        end
        count_m[i] = '0;
        if (by_target)
        begin
            tgt_hit_m[i] = 1'b1;
            if (mode_m[i][MB_IRQ_TGT])
                return raise_irq(i, pend);
        end
        else
        begin
            ovf_hit_m[i] = 1'b1;
            if (mode_m[i][MB_IRQ_FFFF])
                return raise_irq(i, pend);
        end
        return 1'b0;
    endfunction

    // Gate edges act before counting in the same tick.
    function automatic void follow_gate(int i, logic level);
        if (gate_m[i] == level)
            return;
        gate_m[i] = level;
        if (!sync_m[i])
            return;
        case (mode_m[i][2:1])
            SYNC_ZERO_FALL: if (!level) count_m[i] = '0;
            SYNC_ZERO_RISE: if (level) count_m[i] = '0;
            SYNC_FREE_FALL: if (!level) sync_m[i] = 1'b0;
            default: ;
        endcase
    endfunction

    function automatic logic may_count(int i);
        logic [1:0] sm;
        sm = mode_m[i][2:1];
        if (!sync_m[i])
            return 1'b1;
        if (i == 2)
            return (sm == SYNC_ZERO_FALL) || (sm == SYNC_ZERO_RISE);
        if (sm == SYNC_PAUSE_HIGH)
            return !gate_m[i];
        if (sm == SYNC_ZERO_FALL)
            return 1'b1;
        return gate_m[i];
    endfunction

    // Expected result of one word, updating the shadow state on the way.
    function automatic rcnt_out_t predict_word(rcnt_in_t w);
        rcnt_out_t  res;
        logic       slow_tick;
        logic       src_pulse;
        logic [1:0] src;
        int         t;
        res = '0;
        t   = int'(w.timer_select);
        if (w.action == ACT_TICK)
        begin
            follow_gate(0, w.gate_level_zero);
            follow_gate(1, w.gate_level_one);
            phase_m++;
            slow_tick = 1'b0;
            if (phase_m >= PRESCALE)
            begin
                phase_m   = 0;
                slow_tick = 1'b1;
            end
            for (int i = 0; i < NUM_CHAN; i++)
            begin
                src = mode_m[i][MB_SRC_HI:MB_SRC_LO];
                if (i == 0)
                    src_pulse = src[0] ? w.dot_tick : 1'b1;
                else if (i == 1)
                    src_pulse = src[0] ? w.hblank_tick : 1'b1;
                else
                    src_pulse = src[1] ? slow_tick : 1'b1;
                if (may_count(i) && src_pulse)
                    res.irq_raise[i] = step_count(i, w.irq_pending[i]);
            end
        end
        else if (w.action == ACT_READ && w.timer_select < NUM_CHAN)
        begin
            case (w.register_offset)
                OFF_COUNT:  res.read_data = count_m[t];
                OFF_TARGET: res.read_data = target_m[t];
                OFF_MODE:
                begin
                    res.read_data = mode_m[t] & ~STATUS_MASK;
                    res.read_data[MB_IRQ_FLAG] = (tgt_hit_m[t] && mode_m[t][MB_IRQ_TGT]) ||
                                                 (ovf_hit_m[t] && mode_m[t][MB_IRQ_FFFF]);
                    res.read_data[MB_TGT_HIT] = tgt_hit_m[t];
                    res.read_data[MB_OVF_HIT] = ovf_hit_m[t];
                    tgt_hit_m[t] = 1'b0;
                    ovf_hit_m[t] = 1'b0;
                end
                default: ;
            endcase
        end
        else if (w.action == ACT_WRITE && w.timer_select < NUM_CHAN)
        begin
            case (w.register_offset)
                OFF_COUNT:  count_m[t] = w.write_data;
                OFF_TARGET: target_m[t] = w.write_data;
                OFF_MODE:
                begin
                    mode_m[t] = w.write_data;
                    mode_m[t][MB_IRQ_FLAG] = 1'b0;
                    count_m[t]   = '0;
                    tgt_hit_m[t] = 1'b0;
                    ovf_hit_m[t] = 1'b0;
                    sync_m[t]    = w.write_data[MB_SYNC];
                    if (mode_m[t][MB_IRQ_TGT] && target_m[t] == 16'd0)
                    begin
                        mode_m[t][MB_IRQ_FLAG] = 1'b1;
                        res.irq_raise[t] = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    function automatic logic [15:0] rand16();
        logic [31:0] r;
        r = $urandom;
        return r[15:0];
    endfunction

    function automatic rcnt_in_t random_word();
        logic [31:0] r;
        r = $urandom;
        return r[IN_W-1:0];
    endfunction

    function automatic rcnt_in_t access_word(logic [1:0] act, logic [1:0] sel,
                                             logic [3:0] off, logic [15:0] data);
        rcnt_in_t w;
        w = random_word();
        w.action          = act;
        w.timer_select    = sel;
        w.register_offset = off;
        w.write_data      = data;
        return w;
    endfunction

    // Random tick whose gate levels mostly hold and now and then flip.
    function automatic rcnt_in_t next_tick();
        rcnt_in_t w;
        w = random_word();
        w.action = ACT_TICK;
        if ($urandom_range(3, 0) == 0)
            gate_drive[0] = !gate_drive[0];
        if ($urandom_range(3, 0) == 0)
            gate_drive[1] = !gate_drive[1];
        w.gate_level_zero = gate_drive[0];
        w.gate_level_one  = gate_drive[1];
        if ($urandom_range(1, 0) == 0)
            w.irq_pending = '0;
        return w;
    endfunction

    // Offer one word, wait for it to be taken and record its expected result.
    task automatic send_word(input rcnt_in_t w);
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        expected_q.push_back(predict_word(w));
        words_sent++;
        if (!no_idle && $urandom_range(99, 0) < idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] sel, logic [3:0] off, logic [15:0] data);
        send_word(access_word(ACT_WRITE, sel, off, data));
    endtask

    task automatic read_reg(logic [1:0] sel, logic [3:0] off);
        send_word(access_word(ACT_READ, sel, off, rand16()));
    endtask

    task automatic tick_with(logic dot, logic hbl, logic g0, logic g1, logic [2:0] pend);
        rcnt_in_t w;
        w = random_word();
        w.action          = ACT_TICK;
        w.dot_tick        = dot;
        w.hblank_tick     = hbl;
        w.gate_level_zero = g0;
        w.gate_level_one  = g1;
        w.irq_pending     = pend;
        gate_drive[0]     = g0;
        gate_drive[1]     = g1;
        send_word(w);
    endtask

    // Register map extremes, the unused select, an unmapped offset and the spare action.
    task automatic test_register_map();
        write_reg(2'd0, OFF_TARGET, 16'hFFFF);
        read_reg(2'd0, OFF_TARGET);
        write_reg(2'd2, OFF_COUNT, 16'hFFFF);
        read_reg(2'd2, OFF_COUNT);
        write_reg(SEL_NONE, OFF_TARGET, 16'h1234);
        read_reg(SEL_NONE, OFF_TARGET);
        read_reg(2'd1, OFF_UNMAPPED);
        send_word(access_word(ACT_NONE, 2'd0, OFF_COUNT, 16'hFFFF));
    endtask

    // Falling edge zeroes in sync mode 1; a falling edge frees the counter in sync mode 3.
    task automatic test_gate_sync();
        write_reg(2'd0, OFF_MODE, MODE_SYNC | {13'd0, SYNC_ZERO_FALL, 1'b0});
        write_reg(2'd0, OFF_COUNT, 16'd100);
        tick_with(1'b0, 1'b0, 1'b1, 1'b0, 3'b000);
        tick_with(1'b0, 1'b0, 1'b0, 1'b0, 3'b000);
        write_reg(2'd1, OFF_MODE, MODE_SYNC | {13'd0, SYNC_FREE_FALL, 1'b0});
        tick_with(1'b0, 1'b1, 1'b0, 1'b1, 3'b000);
        tick_with(1'b0, 1'b1, 1'b0, 1'b0, 3'b000);
        read_reg(2'd0, OFF_COUNT);
    endtask

    // Mode write with a zero target, toggle and repeat at target, pending suppression,
    // a count written above the target, and a one-shot pulse at the 0xFFFF wrap.
    task automatic test_irq_forms();
        write_reg(2'd1, OFF_MODE, MODE_IRQ_TGT);
        write_reg(2'd2, OFF_TARGET, 16'd2);
        write_reg(2'd2, OFF_MODE, MODE_RESET_TGT | MODE_IRQ_TGT | MODE_REPEAT | MODE_TOGGLE);
        write_reg(2'd2, OFF_COUNT, 16'h0100);
        tick_with(1'b1, 1'b1, 1'b0, 1'b0, 3'b000);
        tick_with(1'b1, 1'b1, 1'b0, 1'b0, 3'b000);
        tick_with(1'b1, 1'b1, 1'b0, 1'b0, 3'b000);
        tick_with(1'b1, 1'b1, 1'b0, 1'b0, 3'b100);
        tick_with(1'b1, 1'b1, 1'b0, 1'b0, 3'b100);
        read_reg(2'd2, OFF_MODE);
        write_reg(2'd0, OFF_MODE, MODE_IRQ_FFFF);
        write_reg(2'd0, OFF_COUNT, 16'hFFFF);
        tick_with(1'b0, 1'b0, 1'b0, 1'b0, 3'b000);
        read_reg(2'd0, OFF_MODE);
    endtask

    // One counter set up, run for a burst of ticks with some noise, then read back.
    task automatic run_sequence();
        int          t;
        int unsigned burst;
        logic [15:0] tgt;
        logic [15:0] mode;
        t = $urandom_range(2, 0);
        case ($urandom_range(3, 0))
            0:       tgt = rand16();
            1:       tgt = 16'd0;
            default: tgt = 16'($urandom_range(24, 1));
        endcase
        mode = rand16();
        if ($urandom_range(1, 0) == 0)
            mode[MB_SYNC] = 1'b0;
        write_reg(2'(t), OFF_TARGET, tgt);
        write_reg(2'(t), OFF_MODE, mode);
        if ($urandom_range(2, 0) == 0)
        begin
            case ($urandom_range(2, 0))
                0:       write_reg(2'(t), OFF_COUNT, tgt - 16'($urandom_range(2, 0)));
                1:       write_reg(2'(t), OFF_COUNT, 16'hFFFF - 16'($urandom_range(2, 0)));
                default: write_reg(2'(t), OFF_COUNT, rand16());
            endcase
        end
        burst = $urandom_range(40, 4);
        repeat (burst)
        begin
            if ($urandom_range(9, 0) == 0)
                send_word(random_word());
            else if ($urandom_range(19, 0) == 0)
                read_reg(2'($urandom_range(2, 0)), OFF_MODE);
            else
                send_word(next_tick());
        end
        read_reg(2'(t), OFF_MODE);
        read_reg(2'(t), OFF_COUNT);
    endtask

    task automatic pick_pacing();
        case ($urandom_range(2, 0))
            0:       idle_pct = 0;
            1:       idle_pct = 10;
            default: idle_pct = 35;
        endcase
        case ($urandom_range(2, 0))
            0:       stall_pct = 0;
            1:       stall_pct = 10;
            default: stall_pct = 35;
        endcase
    endtask

    task automatic test_random_sequences(int unsigned goal);
        while (words_sent < goal)
        begin
            pick_pacing();
            run_sequence();
        end
    endtask

    task automatic test_random_noise(int unsigned count);
        repeat (count)
            send_word(random_word());
    endtask

    // Back-to-back traffic with neither side pausing.
    task automatic test_full_rate(int unsigned goal);
        no_idle = 1'b1;
        while (words_sent < goal)
            run_sequence();
    endtask

    task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s expected %h, got %h", $realtime, what, want, got);
    endtask

    // Result side stalls in short bursts.
    always @(posedge clk)
    begin
        if (no_idle)
        begin
            result_ready <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if ($urandom_range(99, 0) < stall_pct)
        begin
            result_ready <= 1'b0;
            stall_left   <= $urandom_range(2, 0);
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // Compare each delivered word with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        rcnt_out_t want;
        if (result_valid && result_ready)
        begin
            if (expected_q.size() == 0)
            begin
                note_mismatch("unexpected word, read_data", 16'd0, result.read_data);
            end
            else
            begin
                want = expected_q.pop_front();
                if (result.read_data !== want.read_data)
                    note_mismatch("read_data", want.read_data, result.read_data);
                if (result.irq_raise !== want.irq_raise)
                    note_mismatch("irq_raise", 16'(want.irq_raise), 16'(result.irq_raise));
            end
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            count_m[i]   = '0;
            target_m[i]  = '0;
            mode_m[i]    = '0;
            sync_m[i]    = 1'b0;
            tgt_hit_m[i] = 1'b0;
            ovf_hit_m[i] = 1'b0;
        end
        gate_m[0]     = 1'b0;
        gate_m[1]     = 1'b0;
        gate_drive[0] = 1'b0;
        gate_drive[1] = 1'b0;
        phase_m       = 0;
        idle_pct      = 20;
        stall_pct     = 20;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_map();
        test_gate_sync();
        test_irq_forms();
        test_random_sequences(1100);
        test_random_noise(200);
        test_full_rate(1580);

        // Let the last results drain.
        item_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[three_channel_gated_root_counter_core] OK");
        else
            $display("[three_channel_gated_root_counter_core] ERROR");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        #2000000;
        $display("[three_channel_gated_root_counter_core] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
sv/rcnt_pkg.sv
sv/rcnt_prescaler.sv
sv/rcnt_channel.sv
sv/three_channel_gated_root_counter_core.sv
test/tb.sv
